// ===== design/lrs_pkg.sv =====
// Package for the latency running statistics block.
// Holds field widths, parameter defaults, the sequencer state type and the
// status struct that the iterative units hand back. Depends on nothing.
`default_nettype none

package lrs_pkg;

  // Field widths of the request and result channels
  localparam int unsigned LRS_IN_W     = 32;
  localparam int unsigned LRS_COUNT_W  = 32;
  localparam int unsigned LRS_SUM_W    = 64;
  localparam int unsigned LRS_EXTREM_W = 32;
  localparam int unsigned LRS_MEAN_W   = 48;
  localparam int unsigned LRS_M2_W     = 64;

  // Defaults of the top-level parameters
  localparam int unsigned LRS_SAMPLE_BITS        = 32;
  localparam int unsigned LRS_MEAN_FRACTION_BITS = 16;

  // Default operand width of the divider and multiplier
  localparam int unsigned LRS_MAG_W = 48;

  // Multiplier digit taken per cycle
  localparam int unsigned LRS_DIG_W = 16;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MEAN,
    ST_MUL,
    ST_DONE
  } lrs_state_e;

  // Status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } lrs_unit_sts_t;

endpackage

`default_nettype wire

// ===== design/lrs_if.sv =====
// Channel interfaces of the latency running statistics block.
// lrs_sample_if carries one latency sample, lrs_result_if all statistics.
// Depends on lrs_pkg for the field widths.
`default_nettype none

interface lrs_sample_if;
  import lrs_pkg::*;

  logic                valid;
  logic                ready;
  logic [LRS_IN_W-1:0] latency_sample;

  modport source (output valid, output latency_sample, input ready);
  modport sink   (input valid, input latency_sample, output ready);
endinterface

interface lrs_result_if;
  import lrs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [LRS_COUNT_W-1:0]  count_out;
  logic [LRS_SUM_W-1:0]    sum_out;
  logic [LRS_EXTREM_W-1:0] minimum_out;
  logic [LRS_EXTREM_W-1:0] maximum_out;
  logic [LRS_MEAN_W-1:0]   mean_out;
  logic [LRS_M2_W-1:0]     deviation_sum_out;

  modport source (
    output valid, output count_out, output sum_out, output minimum_out,
    output maximum_out, output mean_out, output deviation_sum_out,
    input ready
  );
  modport sink (
    input valid, input count_out, input sum_out, input minimum_out,
    input maximum_out, input mean_out, input deviation_sum_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/latency_running_statistics.sv =====
// Latency running statistics: one request carries a latency sample, one result
// returns count, sum, minimum, maximum, running mean (MEAN_FRACTION_BITS
// fraction bits) and M2 by Welford's method. One sample is in work at a time:
// a new sample is taken only after the divider, the mean step, the multiplier
// and the completion state have run, and the completion state waits while the
// previous result is still held at the output. The radix-2 divider that forms
// the mean step takes one quotient bit per cycle, and the multiplier for the
// M2 term takes one 16-bit digit per cycle. A finished result sits in an output
// register, so the next sample may be taken while it waits. Depends on lrs_pkg,
// lrs_if, lrs_divider and lrs_multiplier. MAG_W is 48 and NDIG is 3 by default.
`default_nettype none

module latency_running_statistics #(
  parameter int unsigned SAMPLE_BITS        = lrs_pkg::LRS_SAMPLE_BITS,
  parameter int unsigned MEAN_FRACTION_BITS = lrs_pkg::LRS_MEAN_FRACTION_BITS
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  lrs_sample_if.sink   sample_i,
  lrs_result_if.source result_o
);
  import lrs_pkg::*;

  // Effective sample width, scaled-sample width and magnitude width
  localparam int unsigned SMP_W = (SAMPLE_BITS < LRS_IN_W) ? SAMPLE_BITS : LRS_IN_W;
  localparam int unsigned XS_W  = SMP_W + MEAN_FRACTION_BITS;
  localparam int unsigned MAG_W = (XS_W > LRS_MEAN_W) ? XS_W : LRS_MEAN_W;
  localparam int unsigned NDIG  = (MAG_W + LRS_DIG_W - 1) / LRS_DIG_W;
  localparam int unsigned PW    = MAG_W + NDIG * LRS_DIG_W;
  localparam int unsigned SHIFT = 2 * MEAN_FRACTION_BITS;

  lrs_state_e state_q, state_d;

  // Running state
  logic [LRS_COUNT_W-1:0]  count_q;
  logic [LRS_SUM_W-1:0]    total_q;
  logic [LRS_EXTREM_W-1:0] min_q;
  logic [LRS_EXTREM_W-1:0] max_q;
  logic [LRS_MEAN_W-1:0]   mean_q;
  logic [LRS_M2_W-1:0]     m2_q;

  // Per-item working registers
  logic [MAG_W-1:0] xs_q;
  logic [MAG_W-1:0] mag1_q;
  logic             neg1_q;
  logic             skip_q;

  // Output register
  logic                    out_valid_q;
  logic [LRS_COUNT_W-1:0]  res_count_q;
  logic [LRS_SUM_W-1:0]    res_total_q;
  logic [LRS_EXTREM_W-1:0] res_min_q;
  logic [LRS_EXTREM_W-1:0] res_max_q;
  logic [LRS_MEAN_W-1:0]   res_mean_q;
  logic [LRS_M2_W-1:0]     res_m2_q;

  // Control
  logic accept;
  logic div_start;
  logic mul_start;
  logic commit;
  logic out_free;

  // Combinational datapath
  logic [LRS_EXTREM_W-1:0] x;
  logic [MAG_W-1:0]        xs;
  logic [MAG_W-1:0]        mean_ext;
  logic                    neg1;
  logic [MAG_W-1:0]        mag1;
  logic [LRS_COUNT_W-1:0]  count_next;
  logic [LRS_SUM_W:0]      total_sum;
  logic [MAG_W-1:0]        quotient;
  logic [MAG_W-1:0]        mean_step;
  logic [LRS_MEAN_W-1:0]   mean_new;
  logic [MAG_W-1:0]        mean_new_ext;
  logic                    neg2;
  logic [MAG_W-1:0]        mag2;
  logic [PW-1:0]           product;
  logic [PW-1:0]           prod_sh;
  logic [LRS_M2_W-1:0]     term;
  logic [LRS_M2_W:0]       m2_sum;
  logic [LRS_M2_W-1:0]     m2_new;

  lrs_unit_sts_t div_sts;
  lrs_unit_sts_t mul_sts;

  // Mask the sample, take its difference from the mean and form the next count and sum
  always_comb begin
    x          = LRS_EXTREM_W'(sample_i.latency_sample[SMP_W-1:0]);
    xs         = MAG_W'(x) << MEAN_FRACTION_BITS;
    mean_ext   = MAG_W'(mean_q);
    neg1       = xs < mean_ext;
    mag1       = neg1 ? (mean_ext - xs) : (xs - mean_ext);
    count_next = (count_q == '1) ? count_q : count_q + LRS_COUNT_W'(1);
    total_sum  = {1'b0, total_q} + (LRS_SUM_W + 1)'(x);
  end

  // Step the mean and take the second difference
  always_comb begin
    mean_step    = neg1_q ? (mean_ext - quotient) : (mean_ext + quotient);
    mean_new     = mean_step[LRS_MEAN_W-1:0];
    mean_new_ext = MAG_W'(mean_new);
    neg2         = xs_q < mean_new_ext;
    mag2         = neg2 ? (mean_new_ext - xs_q) : (xs_q - mean_new_ext);
  end

  // Scale the product down and add it to M2, saturating; differences of unlike sign add nothing
  always_comb begin
    prod_sh = product >> SHIFT;
    if (skip_q) begin
      term = '0;
    end else if (|prod_sh[PW-1:LRS_M2_W]) begin
      term = '1;
    end else begin
      term = prod_sh[LRS_M2_W-1:0];
    end
    m2_sum = {1'b0, m2_q} + {1'b0, term};
    m2_new = m2_sum[LRS_M2_W] ? '1 : m2_sum[LRS_M2_W-1:0];
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_d   = state_q;
    out_free  = !out_valid_q || result_o.ready;
    accept    = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    commit    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          accept    = 1'b1;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN: begin
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (mul_sts.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Update the running statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      min_q   <= '1;
      max_q   <= '0;
      mean_q  <= '0;
      m2_q    <= '0;
    end else begin
      if (accept) begin
        count_q <= count_next;
        total_q <= total_sum[LRS_SUM_W] ? '1 : total_sum[LRS_SUM_W-1:0];
        if (x < min_q) begin
          min_q <= x;
        end
        if (x > max_q) begin
          max_q <= x;
        end
      end
      if (mul_start) begin
        mean_q <= mean_new;
      end
      if (commit) begin
        m2_q <= m2_new;
      end
    end
  end

  // Hold per-item operands
  always_ff @(posedge clk_i) begin
    if (accept) begin
      xs_q   <= xs;
      mag1_q <= mag1;
      neg1_q <= neg1;
    end
    if (mul_start) begin
      skip_q <= neg1_q != neg2;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_count_q <= count_q;
      res_total_q <= total_q;
      res_min_q   <= min_q;
      res_max_q   <= max_q;
      res_mean_q  <= mean_q;
      res_m2_q    <= m2_new;
    end
  end

  lrs_divider #(
    .MAG_W (MAG_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag1),
    .divisor_i  (count_next),
    .sts_o      (div_sts),
    .quotient_o (quotient)
  );

  lrs_multiplier #(
    .MAG_W (MAG_W),
    .NDIG  (NDIG),
    .PW    (PW)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mag1_q),
    .b_i       (mag2),
    .sts_o     (mul_sts),
    .product_o (product)
  );

  // Drive the channels
  assign sample_i.ready             = (state_q == ST_IDLE);
  assign result_o.valid             = out_valid_q;
  assign result_o.count_out         = res_count_q;
  assign result_o.sum_out           = res_total_q;
  assign result_o.minimum_out       = res_min_q;
  assign result_o.maximum_out       = res_max_q;
  assign result_o.mean_out          = res_mean_q;
  assign result_o.deviation_sum_out = res_m2_q;

  // No request is taken while either unit is working
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.ready |-> !div_sts.busy && !mul_sts.busy)
    else $error("request taken while an arithmetic unit is busy");

  // The divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> state_q == ST_DIV)
    else $error("divider finished outside its wait state");

  // The count never goes down
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q >= $past(count_q))
    else $error("sample count decreased");

  // Once a sample is in, the minimum does not exceed the maximum
  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> min_q <= max_q)
    else $error("minimum above maximum");

  // A result appears only on leaving the completion state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside completion");

endmodule

`default_nettype wire

// ===== design/lrs_divider.sv =====
// Radix-2 restoring divider: one quotient bit per cycle, MAG_W quotient bits.
// Divides an unsigned MAG_W-bit magnitude by the 32-bit sample count.
// Depends on lrs_pkg.
`default_nettype none

module lrs_divider #(
  parameter int unsigned MAG_W = lrs_pkg::LRS_MAG_W
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  input  wire  [MAG_W-1:0]               dividend_i,
  input  wire  [lrs_pkg::LRS_COUNT_W-1:0] divisor_i,
  output lrs_pkg::lrs_unit_sts_t         sts_o,
  output logic [MAG_W-1:0]               quotient_o
);
  import lrs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAG_W + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [MAG_W-1:0]       quo_q;
  logic [LRS_COUNT_W-1:0] rem_q;
  logic [LRS_COUNT_W-1:0] den_q;

  logic [LRS_COUNT_W:0]   rem_sh;
  logic                   fits;
  logic [LRS_COUNT_W:0]   rem_sub;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem_q, quo_q[MAG_W-1]};
    fits    = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // Sequence the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(MAG_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Load operands, then shift quotient bits in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[MAG_W-2:0], fits};
      rem_q <= fits ? rem_sub[LRS_COUNT_W-1:0] : rem_sh[LRS_COUNT_W-1:0];
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

  // Remainder stays below the divisor while stepping
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |-> rem_q < den_q || den_q == '0)
    else $error("divider remainder not below divisor");

  // Done follows the last busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without preceding busy");

  // A step count is loaded whenever the unit is busy
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with empty step count");

endmodule

`default_nettype wire

// ===== design/lrs_multiplier.sv =====
// Digit-serial multiplier: one 16-bit digit of the second operand per cycle.
// Forms the full unsigned product of two MAG_W-bit magnitudes.
// Depends on lrs_pkg.
`default_nettype none

module lrs_multiplier #(
  parameter int unsigned MAG_W = lrs_pkg::LRS_MAG_W,
  parameter int unsigned NDIG  = (lrs_pkg::LRS_MAG_W + lrs_pkg::LRS_DIG_W - 1)
                                 / lrs_pkg::LRS_DIG_W,
  parameter int unsigned PW    = lrs_pkg::LRS_MAG_W + NDIG * lrs_pkg::LRS_DIG_W
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start_i,
  input  wire  [MAG_W-1:0]       a_i,
  input  wire  [MAG_W-1:0]       b_i,
  output lrs_pkg::lrs_unit_sts_t sts_o,
  output logic [PW-1:0]          product_o
);
  import lrs_pkg::*;

  localparam int unsigned BW    = NDIG * LRS_DIG_W;
  localparam int unsigned MUL_W = MAG_W + LRS_DIG_W;
  localparam int unsigned CNT_W = $clog2(NDIG + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] a_q;
  logic [PW-1:0]    prod_q;

  logic [MUL_W-1:0] part;
  logic [MUL_W-1:0] acc;

  // Partial product of the low digit, added to the upper half
  always_comb begin
    part = MUL_W'(a_q) * MUL_W'(prod_q[LRS_DIG_W-1:0]);
    acc  = MUL_W'(prod_q[PW-1 -: MAG_W]) + part;
  end

  // Sequence the digits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NDIG);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Load operands, then shift the product right one digit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= PW'(BW'(b_i));
    end else if (busy_q) begin
      prod_q <= {acc, prod_q[BW-1:LRS_DIG_W]};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign product_o  = prod_q;

  // Done follows the last busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("multiplier done without preceding busy");

  // Product register holds once the digits are used up
  a_hold_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !start_i |=> $stable(prod_q) || start_i || $past(start_i))
    else $error("multiplier product moved after completion");

  // A digit count is loaded whenever the unit is busy
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("multiplier busy with empty digit count");

endmodule

`default_nettype wire
